@@ src/head_split_time_search_unit_assert.svh @@
// assertion macros for the head split time search unit
`ifndef HEAD_SPLIT_TIME_SEARCH_UNIT_ASSERT_SVH
`define HEAD_SPLIT_TIME_SEARCH_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define HSTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define HSTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hsts_pkg.sv @@
// shared types and constants of the head split time search unit
package hsts_pkg;

  localparam int MAX_PROCS = 8;
  localparam int MAX_HEADS = 64;
  localparam int PROC_W    = 3;
  localparam int SLOT_W    = 6;
  localparam int ADDR_W    = PROC_W + SLOT_W;
  localparam int TBL_DEPTH = MAX_PROCS * MAX_HEADS;
  localparam int TIME_W    = 24;
  localparam int POS_W     = 26;
  localparam int GAP_W     = 25;
  localparam int HEADS_W   = 7;
  localparam int TOTAL_W   = 10;
  localparam int WANT_W    = 8;
  localparam int LIMIT_W   = 20;

  localparam logic signed [POS_W-1:0] ONE_MS = 26'sd16;

  // configuration register indexes
  localparam logic [1:0] CFG_HEAD_COUNT     = 2'd0;
  localparam logic [1:0] CFG_PROC_COUNT     = 2'd1;
  localparam logic [1:0] CFG_DIFF_THRESHOLD = 2'd2;

  localparam logic [6:0]  HEAD_COUNT_RST     = 7'd12;
  localparam logic [3:0]  PROC_COUNT_RST     = 4'd2;
  localparam logic [15:0] DIFF_THRESHOLD_RST = 16'd300;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_CHECK,
    ST_PROBE,
    ST_DECIDE,
    ST_EMIT
  } hsts_state_t;

endpackage

@@ src/hsts_ram.sv @@
// generic single write port ram with registered read
module hsts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/head_split_time_search_unit.sv @@
// head split time search unit: profiling table load, binary time search, head allocation
// operation: an entry without tlast is only stored; an entry with tlast also starts a min scan
//   over the all-heads entry of each processor, then probes that each read all np*len entries,
//   then np result words (np = clamped proc_count, len = clamped head_count)
// throughput: one entry per cycle while loading; one table read per cycle in the search
// reset: rst_n synchronous active low, clears control, config to defaults; table not cleared
module head_split_time_search_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream; tdata from lsb: proc_index[2:0], head_slot[8:3], time_value[32:9], zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        in_tlast,   // last_entry
  // result stream; tdata from lsb: out_proc[2:0], out_heads[9:3], out_time[33:10], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tuser,  // found
  output logic        out_tlast,  // last_result
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int PW = hsts_pkg::PROC_W;
  localparam int SW = hsts_pkg::SLOT_W;
  localparam int AW = hsts_pkg::ADDR_W;
  localparam int TW = hsts_pkg::TIME_W;
  localparam int XW = hsts_pkg::POS_W;
  localparam int GW = hsts_pkg::GAP_W;
  localparam int HW = hsts_pkg::HEADS_W;
  localparam int CW = hsts_pkg::TOTAL_W;
  localparam int WW = hsts_pkg::WANT_W;
  localparam int LW = hsts_pkg::LIMIT_W;
  localparam int NP = hsts_pkg::MAX_PROCS;

  // configuration registers
  logic [6:0]  head_count_r;
  logic [3:0]  proc_count_r;
  logic [15:0] diff_threshold_r;

  // sequencer
  hsts_pkg::hsts_state_t st_r, st_nxt;

  // read issue side
  logic          iss_act_r, iss_act_nxt;
  logic [PW-1:0] p_cnt_r, p_cnt_nxt;
  logic [SW-1:0] s_cnt_r, s_cnt_nxt;

  // tags that travel with the registered read data
  logic          rd_vld_r;
  logic          rd_lasts_r;
  logic          rd_end_r;
  logic [PW-1:0] rd_p_r;
  logic [SW-1:0] rd_s_r;

  // search state
  logic signed [XW-1:0] low_r, low_nxt;
  logic signed [XW-1:0] high_r, high_nxt;
  logic signed [XW-1:0] mid_r, mid_nxt;
  logic [TW-1:0]        min_r, min_nxt;
  logic [GW-1:0]        bgap_r, bgap_nxt;
  logic [HW-1:0]        bpick_r, bpick_nxt;
  logic [CW-1:0]        total_r, total_nxt;
  logic [HW-1:0]        cnt_r [NP];
  logic [HW-1:0]        best_heads_r [NP];
  logic [TW-1:0]        best_time_r, best_time_nxt;
  logic                 found_r, found_nxt;

  // result emission
  logic [PW-1:0]        e_cnt_r, e_cnt_nxt;
  logic signed [WW-1:0] want_r, want_nxt;

  // output register
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [39:0] out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r, out_tuser_nxt;
  logic        out_tlast_r, out_tlast_nxt;

  // clamped configuration
  logic [PW-1:0] np_m1;
  logic [SW-1:0] len_m1;
  logic [LW-1:0] limit;

  // table memory
  logic          in_fire;
  logic [AW-1:0] raddr;
  logic [TW-1:0] rdata;

  // issue decode
  logic iss_lasts;
  logic iss_end;

  // shared gap unit
  logic [TW-1:0]        tr;
  logic signed [XW-1:0] diff;
  logic [XW-1:0]        mag;
  logic [GW-1:0]        gap;
  logic                 take;
  logic [GW-1:0]        cur_gap;
  logic [HW-1:0]        cur_pick;
  logic [HW-1:0]        fin_pick;
  logic                 success;

  // emission datapath
  logic                 out_space;
  logic [HW-1:0]        h_raw;
  logic signed [WW-1:0] h_s;
  logic [HW-1:0]        h_out;

  assign in_tready  = (st_r == hsts_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_space  = !out_tvalid_r || out_tready;

  // processors present minus one, clamped to the table
  always_comb begin
    if (proc_count_r == 4'd0) begin
      np_m1 = '0;
    end else if (proc_count_r > 4'(NP)) begin
      np_m1 = PW'(NP - 1);
    end else begin
      np_m1 = PW'(proc_count_r - 4'd1);
    end
  end

  // entries per processor minus one
  always_comb begin
    if (head_count_r == 7'd0) begin
      len_m1 = '0;
    end else if (head_count_r > 7'(hsts_pkg::MAX_HEADS)) begin
      len_m1 = SW'(hsts_pkg::MAX_HEADS - 1);
    end else begin
      len_m1 = SW'(head_count_r - 7'd1);
    end
  end

  assign limit = {diff_threshold_r, 4'h0};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_count_r     <= hsts_pkg::HEAD_COUNT_RST;
      proc_count_r     <= hsts_pkg::PROC_COUNT_RST;
      diff_threshold_r <= hsts_pkg::DIFF_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hsts_pkg::CFG_HEAD_COUNT:     head_count_r     <= cfg_wdata[6:0];
        hsts_pkg::CFG_PROC_COUNT:     proc_count_r     <= cfg_wdata[3:0];
        hsts_pkg::CFG_DIFF_THRESHOLD: diff_threshold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // profiling table, written by entries, read by the search one entry per cycle
  hsts_ram #(
    .WIDTH (TW),
    .DEPTH (hsts_pkg::TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (in_fire),
    .waddr ({in_tdata[2:0], in_tdata[8:3]}),
    .wdata (in_tdata[32:9]),
    .raddr (raddr),
    .rdata (rdata)
  );

  // min scan reads the all-heads entry of each processor, a probe reads every entry
  always_comb begin
    if (st_r == hsts_pkg::ST_MIN) begin
      raddr     = {p_cnt_r, len_m1};
      iss_lasts = 1'b1;
    end else begin
      raddr     = {p_cnt_r, s_cnt_r};
      iss_lasts = (s_cnt_r == len_m1);
    end
    iss_end = iss_lasts && (p_cnt_r == np_m1);
  end

  // shared gap unit: distance of the truncated entry to the probe, first closest wins
  always_comb begin
    tr       = {rdata[TW-1:4], 4'h0};
    diff     = $signed({{(XW-TW){1'b0}}, tr}) - mid_r;
    mag      = diff[XW-1] ? XW'(-diff) : XW'(diff);
    gap      = mag[GW-1:0];
    take     = (rd_s_r == '0) || (gap < bgap_r);
    cur_gap  = take ? gap : bgap_r;
    cur_pick = take ? (HW'(rd_s_r) + HW'(1)) : bpick_r;
    fin_pick = (cur_gap >= GW'(limit)) ? '0 : cur_pick;
    success  = (total_r >= CW'(head_count_r));
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      hsts_pkg::ST_IDLE: begin
        if (in_fire && in_tlast) begin
          st_nxt = hsts_pkg::ST_MIN;
        end
      end
      hsts_pkg::ST_MIN: begin
        if (rd_vld_r && rd_end_r) begin
          st_nxt = hsts_pkg::ST_CHECK;
        end
      end
      hsts_pkg::ST_CHECK: begin
        st_nxt = (low_r <= high_r) ? hsts_pkg::ST_PROBE : hsts_pkg::ST_EMIT;
      end
      hsts_pkg::ST_PROBE: begin
        if (rd_vld_r && rd_end_r) begin
          st_nxt = hsts_pkg::ST_DECIDE;
        end
      end
      hsts_pkg::ST_DECIDE: begin
        st_nxt = hsts_pkg::ST_CHECK;
      end
      hsts_pkg::ST_EMIT: begin
        if (out_space && (e_cnt_r == np_m1)) begin
          st_nxt = hsts_pkg::ST_IDLE;
        end
      end
      default: st_nxt = hsts_pkg::ST_IDLE;
    endcase
  end

  // correction of the head count of the processor being emitted
  always_comb begin
    h_raw    = found_r ? best_heads_r[e_cnt_r] : '0;
    h_s      = $signed({1'b0, h_raw});
    h_out    = h_raw;
    want_nxt = want_r;
    if (st_r == hsts_pkg::ST_CHECK) begin
      want_nxt = $signed({1'b0, head_count_r});
    end else if ((st_r == hsts_pkg::ST_EMIT) && out_space && found_r) begin
      if (e_cnt_r == '0) begin
        want_nxt = want_r - h_s;
      end else if (h_s > want_r) begin
        h_out    = want_r[WW-1] ? '0 : want_r[HW-1:0];
        want_nxt = '0;
      end else begin
        want_nxt = want_r - h_s;
      end
    end
  end

  // datapath and control next values
  always_comb begin
    iss_act_nxt    = iss_act_r;
    p_cnt_nxt      = p_cnt_r;
    s_cnt_nxt      = s_cnt_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    mid_nxt        = mid_r;
    min_nxt        = min_r;
    bgap_nxt       = bgap_r;
    bpick_nxt      = bpick_r;
    total_nxt      = total_r;
    best_time_nxt  = best_time_r;
    found_nxt      = found_r;
    e_cnt_nxt      = e_cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;

    // read issue walks processors and slots
    if (iss_act_r) begin
      if (iss_lasts) begin
        s_cnt_nxt = '0;
        p_cnt_nxt = p_cnt_r + PW'(1);
      end else begin
        s_cnt_nxt = s_cnt_r + SW'(1);
      end
      if (iss_end) begin
        iss_act_nxt = 1'b0;
      end
    end

    case (st_r)
      hsts_pkg::ST_IDLE: begin
        if (in_fire && in_tlast) begin
          iss_act_nxt   = 1'b1;
          p_cnt_nxt     = '0;
          s_cnt_nxt     = '0;
          min_nxt       = '1;
          low_nxt       = '0;
          found_nxt     = 1'b0;
          best_time_nxt = '0;
        end
      end
      hsts_pkg::ST_MIN: begin
        if (rd_vld_r) begin
          min_nxt = (rdata < min_r) ? rdata : min_r;
          if (rd_end_r) begin
            high_nxt = $signed({{(XW-TW){1'b0}}, min_nxt});
          end
        end
      end
      hsts_pkg::ST_CHECK: begin
        mid_nxt   = low_r + ((high_r - low_r) >>> 1);
        total_nxt = '0;
        e_cnt_nxt = '0;
        if (low_r <= high_r) begin
          iss_act_nxt = 1'b1;
          p_cnt_nxt   = '0;
          s_cnt_nxt   = '0;
        end
      end
      hsts_pkg::ST_PROBE: begin
        if (rd_vld_r) begin
          bgap_nxt  = cur_gap;
          bpick_nxt = cur_pick;
          if (rd_lasts_r) begin
            total_nxt = total_r + CW'(fin_pick);
          end
        end
      end
      hsts_pkg::ST_DECIDE: begin
        if (success) begin
          found_nxt     = 1'b1;
          best_time_nxt = mid_r[TW-1:0];
          high_nxt      = mid_r - hsts_pkg::ONE_MS;
        end else begin
          low_nxt = mid_r + hsts_pkg::ONE_MS;
        end
      end
      hsts_pkg::ST_EMIT: begin
        if (out_space) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'h0, (found_r ? best_time_r : TW'(0)), h_out, e_cnt_r};
          out_tuser_nxt  = found_r;
          out_tlast_nxt  = (e_cnt_r == np_m1);
          e_cnt_nxt      = e_cnt_r + PW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= hsts_pkg::ST_IDLE;
      iss_act_r    <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      found_r      <= 1'b0;
      p_cnt_r      <= '0;
      s_cnt_r      <= '0;
      e_cnt_r      <= '0;
    end else begin
      st_r         <= st_nxt;
      iss_act_r    <= iss_act_nxt;
      rd_vld_r     <= iss_act_r;
      out_tvalid_r <= out_tvalid_nxt;
      found_r      <= found_nxt;
      p_cnt_r      <= p_cnt_nxt;
      s_cnt_r      <= s_cnt_nxt;
      e_cnt_r      <= e_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_lasts_r  <= iss_lasts;
    rd_end_r    <= iss_end;
    rd_p_r      <= p_cnt_r;
    rd_s_r      <= (st_r == hsts_pkg::ST_MIN) ? len_m1 : s_cnt_r;
    low_r       <= low_nxt;
    high_r      <= high_nxt;
    mid_r       <= mid_nxt;
    min_r       <= min_nxt;
    bgap_r      <= bgap_nxt;
    bpick_r     <= bpick_nxt;
    total_r     <= total_nxt;
    best_time_r <= best_time_nxt;
    want_r      <= want_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
    // per-processor count of the running probe
    if ((st_r == hsts_pkg::ST_PROBE) && rd_vld_r && rd_lasts_r) begin
      cnt_r[rd_p_r] <= fin_pick;
    end
    // counts of the last successful probe
    if ((st_r == hsts_pkg::ST_DECIDE) && success) begin
      best_heads_r <= cnt_r;
    end
  end

`include "head_split_time_search_unit_assert.svh"

  // a word without a successful probe carries no heads
  `HSTS_ASSERT_NOW(a_no_found_no_heads, out_tvalid_r && !out_tuser_r, out_tdata_r[9:3] == '0, "heads without a successful probe")

  // the probe time never goes negative
  `HSTS_ASSERT_NOW(a_probe_nonneg, st_r == hsts_pkg::ST_PROBE, !mid_r[XW-1], "negative probe time")

  // after the final result word the unit takes entries again
  `HSTS_ASSERT_NEXT(a_emit_done, (st_r == hsts_pkg::ST_EMIT) && out_space && (e_cnt_r == np_m1), in_tready, "unit not idle after last result")

  // no table read in flight while entries are accepted
  `HSTS_ASSERT_NOW(a_idle_no_reads, in_tready, !iss_act_r && !rd_vld_r, "table read while idle")

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the head split time search unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsts_pkg::*;

  // one allocation word as the block reports it
  typedef struct packed {
    logic [PROC_W-1:0]  proc;
    logic [HEADS_W-1:0] heads;
    logic [TIME_W-1:0]  tm;
    logic               found;
    logic               last;
  } alloc_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  // one line of the directed table: a register write or a profiling word
  typedef struct {
    row_kind_e          kind;
    logic [1:0]         idx;
    logic [15:0]        val;
    logic [PROC_W-1:0]  proc;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  tv;
    bit                 last;
    bit                 no_fit;   // typed-in outcome: no probe can succeed
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // proc_index, head_slot, time_value, zero pad
  logic        in_tlast = 1'b0; // last_entry
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // out_proc, out_heads, out_time, zero pad
  logic        out_tuser;       // found
  logic        out_tlast;       // last_result
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // shadow of the profiling table; prof_set marks entries the run has written,
  // so a search is never started over an entry that was never loaded
  logic [TIME_W-1:0] prof_time [TBL_DEPTH];
  bit                prof_set  [TBL_DEPTH];

  // shadow of the configuration registers
  logic [6:0]  cur_heads = HEAD_COUNT_RST;
  logic [3:0]  cur_procs = PROC_COUNT_RST;
  logic [15:0] cur_thr   = DIFF_THRESHOLD_RST;

  // allocation words still owed by the block, oldest first
  alloc_t alloc_q [$];

  int err_count      = 0;
  int words_sent     = 0;
  int searches       = 0;
  int allocs_checked = 0;
  int phases         = 0;

  // calm: no idling on either side; hold_trigger asks the receiver for a long stall
  bit calm         = 1'b0;
  bit hold_trigger = 1'b0;
  int hold_left    = 0;

  step_row_t steps [21];

  head_split_time_search_unit DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

  // clamped table length and processor count, as the block sees them
  function automatic int procs_in_use();
    if (cur_procs == 4'd0) return 1;
    if (int'(cur_procs) > MAX_PROCS) return MAX_PROCS;
    return int'(cur_procs);
  endfunction

  function automatic int slots_in_use();
    if (cur_heads == 7'd0) return 1;
    if (int'(cur_heads) > MAX_HEADS) return MAX_HEADS;
    return int'(cur_heads);
  endfunction

  // binary search over target times, then per-processor head correction;
  // appends one allocation word per processor to alloc_q
  function automatic void plan_head_split();
    int np, len, lo, hi, mid, total, want, h, limit, step;
    logic [TIME_W-1:0] min_t, best_t;
    int best_h [MAX_PROCS];
    int cnt [MAX_PROCS];
    bit hit;
    alloc_t a;
    np    = procs_in_use();
    len   = slots_in_use();
    step  = int'(ONE_MS);
    limit = int'(cur_thr) * step;
    // upper bound: fastest all-heads time among the processors present
    min_t = '1;
    for (int p = 0; p < np; p++)
      if (prof_time[p * MAX_HEADS + len - 1] < min_t) min_t = prof_time[p * MAX_HEADS + len - 1];
    hit    = 1'b0;
    best_t = '0;
    foreach (best_h[p]) best_h[p] = 0;
    lo = 0;
    hi = int'(min_t);
    while (lo <= hi) begin
      mid   = lo + (hi - lo) / 2;
      total = 0;
      for (int p = 0; p < np; p++) begin
        int gap, best_gap, trunc;
        cnt[p]   = 0;
        best_gap = 0;
        // closest truncated time wins, ties keep the smaller head count
        for (int s = 0; s < len; s++) begin
          trunc = (int'(prof_time[p * MAX_HEADS + s]) >> 4) << 4;
          gap   = trunc - mid;
          if (gap < 0) gap = -gap;
          if (s == 0 || gap < best_gap) begin
            best_gap = gap;
            cnt[p]   = s + 1;
          end
        end
        if (best_gap >= limit) cnt[p] = 0;
        total += cnt[p];
      end
      if (total >= int'(cur_heads)) begin
        hit    = 1'b1;
        best_t = mid[TIME_W-1:0];
        best_h = cnt;
        hi     = mid - step;
      end else begin
        lo = mid + step;
      end
    end
    // cpu keeps its share, the others are capped to what is still wanted
    want = int'(cur_heads);
    for (int p = 0; p < np; p++) begin
      h = hit ? best_h[p] : 0;
      if (hit) begin
        if (p == 0) begin
          want -= h;
        end else if (h > want) begin
          h    = (want < 0) ? 0 : want;
          want = 0;
        end else begin
          want -= h;
        end
      end
      a.proc  = p[PROC_W-1:0];
      a.heads = h[HEADS_W-1:0];
      a.tm    = hit ? best_t : '0;
      a.found = hit;
      a.last  = (p == np - 1);
      alloc_q.push_back(a);
    end
    searches++;
  endfunction

  function automatic step_row_t cfg_row(logic [1:0] idx, logic [15:0] val);
    step_row_t r;
    r = '{ROW_CFG, idx, val, '0, '0, '0, 1'b0, 1'b0};
    return r;
  endfunction

  function automatic step_row_t word_row(logic [PROC_W-1:0] proc, logic [SLOT_W-1:0] slot,
                                         logic [TIME_W-1:0] tv, bit last, bit no_fit);
    step_row_t r;
    r = '{ROW_WORD, '0, '0, proc, slot, tv, last, no_fit};
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // register write, only called while the block is idle
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEAD_COUNT:     cur_heads = value[6:0];
      CFG_PROC_COUNT:     cur_procs = value[3:0];
      CFG_DIFF_THRESHOLD: cur_thr   = value;
      default: ;
    endcase
  endtask

  // offer one profiling word, with random idle cycles ahead of it;
  // on acceptance update the table shadow and, on tlast, the expectations
  task automatic send_word(input logic [PROC_W-1:0] proc, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_W-1:0] tv, input bit last, input bit no_fit);
    int addr, np;
    alloc_t a;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, tv, slot, proc};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    addr = int'(proc) * MAX_HEADS + int'(slot);
    prof_time[addr] = tv;
    prof_set[addr]  = 1'b1;
    if (last) begin
      if (no_fit) begin
        np = procs_in_use();
        for (int p = 0; p < np; p++) begin
          a = '{proc: p[PROC_W-1:0], heads: '0, tm: '0, found: 1'b0, last: (p == np - 1)};
          alloc_q.push_back(a);
        end
        searches++;
      end else begin
        plan_head_split();
      end
    end
  endtask

  // stop offering, wait for every owed word, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (alloc_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver: random back-pressure, plus one long stall on request
  always @(negedge clk) begin
    if (hold_trigger) begin
      hold_trigger = 1'b0;
      hold_left    = 3000;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 26);
    end
  end

  // result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin : check_results
    alloc_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (alloc_q.size() == 0) begin
        flag_mismatch("unexpected word", out_tdata, 0);
      end else begin
        due = alloc_q.pop_front();
        allocs_checked++;
        if (out_tdata[2:0] != due.proc)    flag_mismatch("out_proc", out_tdata[2:0], due.proc);
        if (out_tdata[9:3] != due.heads)   flag_mismatch("out_heads", out_tdata[9:3], due.heads);
        if (out_tdata[33:10] != due.tm)    flag_mismatch("out_time", out_tdata[33:10], due.tm);
        if (out_tuser != due.found)        flag_mismatch("found", out_tuser, due.found);
        if (out_tlast != due.last)         flag_mismatch("last_result", out_tlast, due.last);
      end
    end
  end

  initial begin
    // directed part: extremes, clamps, a search that cannot succeed
    steps = '{
      cfg_row(CFG_HEAD_COUNT, 16'd2),
      cfg_row(CFG_PROC_COUNT, 16'd2),
      cfg_row(CFG_DIFF_THRESHOLD, 16'hFFFF),
      word_row(3'd0, 6'd0, 24'h000000, 1'b0, 1'b0),
      word_row(3'd0, 6'd1, 24'h000320, 1'b0, 1'b0),
      word_row(3'd1, 6'd0, 24'h000140, 1'b0, 1'b0),
      word_row(3'd1, 6'd1, 24'hFFFFFF, 1'b1, 1'b0),
      // top corner of the table, never searched here
      word_row(3'd7, 6'd63, 24'hFFFFFF, 1'b0, 1'b0),
      word_row(3'd7, 6'd62, 24'h000000, 1'b0, 1'b0),
      // zero threshold: every gap counts as too far, nothing can fit
      cfg_row(CFG_DIFF_THRESHOLD, 16'd0),
      word_row(3'd1, 6'd1, 24'h000200, 1'b1, 1'b1),
      // zero heads and zero processors clamp to one entry, one processor
      cfg_row(CFG_HEAD_COUNT, 16'd0),
      cfg_row(CFG_PROC_COUNT, 16'd0),
      cfg_row(CFG_DIFF_THRESHOLD, 16'd300),
      word_row(3'd0, 6'd0, 24'h00A5A5, 1'b1, 1'b0),
      // one ms threshold: only a near exact hit counts
      cfg_row(CFG_HEAD_COUNT, 16'd1),
      cfg_row(CFG_PROC_COUNT, 16'd1),
      cfg_row(CFG_DIFF_THRESHOLD, 16'd1),
      word_row(3'd0, 6'd0, 24'h012345, 1'b1, 1'b0),
      cfg_row(CFG_DIFF_THRESHOLD, 16'hFFFF),
      word_row(3'd0, 6'd0, 24'h000010, 1'b1, 1'b0)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        if (i > 0 && steps[i-1].kind == ROW_WORD) settle();
        cfg_write(steps[i].idx, steps[i].val);
      end else begin
        send_word(steps[i].proc, steps[i].slot, steps[i].tv, steps[i].last, steps[i].no_fit);
      end
    end

    // random part: setting phases, each with a few table loads ending in a search
    while (words_sent < 460) begin
      logic [6:0]  hc;
      logic [3:0]  pc;
      logic [15:0] th;
      int np, len, frames;
      case (phases)
        0: begin   // more heads wanted than the table can ever give
          hc = 7'd127;
          pc = 4'd1;
          th = 16'($urandom_range(100, 3000));
        end
        1: begin   // processor count above the maximum
          hc = 7'd3;
          pc = 4'd15;
          th = 16'hFFFF;
        end
        2: begin   // full table length
          hc = 7'd64;
          pc = 4'd1;
          th = 16'hFFFF;
        end
        3: begin
          hc = 7'($urandom_range(1, 6));
          pc = 4'($urandom_range(1, 4));
          th = 16'd0;
        end
        default: begin
          // mostly small tables so searches stay short
          hc = ($urandom_range(9) == 0) ? 7'($urandom_range(9, 24)) : 7'($urandom_range(1, 8));
          pc = (hc > 7'd8) ? 4'($urandom_range(1, 2)) :
               ($urandom_range(9) == 0) ? 4'($urandom_range(5, 8)) : 4'($urandom_range(1, 4));
          th = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(20, 3000));
        end
      endcase
      settle();
      cfg_write(CFG_HEAD_COUNT, {9'd0, hc});
      cfg_write(CFG_PROC_COUNT, {12'd0, pc});
      cfg_write(CFG_DIFF_THRESHOLD, th);
      calm   = (phases == 5 || phases == 6);
      np     = procs_in_use();
      len    = slots_in_use();
      frames = $urandom_range(3, 6);

      for (int f = 0; f < frames; f++) begin
        int scale [MAX_PROCS];
        int addr_q [$];
        int shape, k, a, tmp, p, s;
        bit full;
        logic [TIME_W-1:0] tv;
        // long receiver stall while the next loads keep coming
        if (phases == 4 && f == 0) hold_trigger = 1'b1;
        // sometimes wait for every owed word before the next load
        if ((phases == 5 && f == 1) || $urandom_range(9) == 0) settle();
        // shape 0..6 rising profile, 7..8 scattered, 9 near full scale
        shape = $urandom_range(9);
        foreach (scale[q]) scale[q] = $urandom_range(1, 400);
        full = (np * len <= 16) && ($urandom_range(1) == 1);
        for (int q = 0; q < np; q++)
          for (int r = 0; r < len; r++)
            if (!prof_set[q * MAX_HEADS + r]) full = 1'b1;
        for (int q = 0; q < np; q++)
          for (int r = 0; r < len; r++)
            if (full || $urandom_range(7) == 0) addr_q.push_back(q * MAX_HEADS + r);
        if (addr_q.size() == 0)
          addr_q.push_back($urandom_range(np - 1) * MAX_HEADS + $urandom_range(len - 1));
        for (int j = addr_q.size() - 1; j > 0; j--) begin
          k         = $urandom_range(j);
          tmp       = addr_q[j];
          addr_q[j] = addr_q[k];
          addr_q[k] = tmp;
        end
        // stray writes anywhere in the table
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, 4))
            send_word(PROC_W'($urandom), SLOT_W'($urandom), TIME_W'($urandom), 1'b0, 1'b0);
        // the region itself, tlast on the final word starts the search
        for (int j = 0; j < addr_q.size(); j++) begin
          a = addr_q[j];
          p = a / MAX_HEADS;
          s = a % MAX_HEADS;
          if (shape <= 6)
            tv = TIME_W'(((scale[p] * (s + 1)) << 4) + int'($urandom_range(0, 47)));
          else if (shape <= 8)
            tv = TIME_W'($urandom);
          else
            tv = TIME_W'($urandom_range(24'hF00000, 24'hFFFFFF));
          send_word(PROC_W'(p), SLOT_W'(s), tv, j == addr_q.size() - 1, 1'b0);
        end
      end
      phases++;
    end
    calm = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    $display("%0d profile words loaded over %0d setting phases, %0d searches run",
             words_sent, phases, searches);
    $display("%0d allocation words compared, %0d mismatches", allocs_checked, err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ head_split_time_search_unit.f @@
+incdir+src
src/hsts_pkg.sv
src/hsts_ram.sv
src/head_split_time_search_unit.sv
tb/tb.sv
